>>> src/newton_nth_root_assert.svh
// ----------------------------------------------------------------------------
// newton_nth_root_assert.svh
// Assertion macros shared by the n-th root block.
// ----------------------------------------------------------------------------
`ifndef NEWTON_NTH_ROOT_ASSERT_SVH
`define NEWTON_NTH_ROOT_ASSERT_SVH

// same-cycle implication, off during reset
`define NNR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define NNR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg
// Types and fixed widths for the Newton n-th root block.
// ----------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

    localparam int RAD_W = 32;     // radicand / root word
    localparam int DEG_W = 4;      // degree field
    localparam int CNT_W = 8;      // iteration count
    localparam int EST_W = 48;     // estimate
    localparam int POW_W = 64;     // powers, denominator, quotient

    localparam logic [POW_W-1:0] POW_MAX = {1'b0, {(POW_W-1){1'b1}}};
    localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
    localparam logic [RAD_W-1:0] OUT_MAX = {RAD_W{1'b1}};

    localparam logic [CNT_W-1:0] ITER_RESET = 8'd100;
    localparam int               START_VALUE = 10;

    // partial-product selects of the 64x64 multiply (a half, b half)
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;
    localparam logic [1:0] PP_HH = 2'd3;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_STEP   = 9'b000000010,
        ST_MUL    = 9'b000000100,
        ST_MULEND = 9'b000001000,
        ST_DEN    = 9'b000010000,
        ST_DIVSET = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_FIN    = 9'b100000000
    } nnr_state_t;

endpackage

`default_nettype wire

>>> src/newton_nth_root.sv
// ----------------------------------------------------------------------------
// newton_nth_root
// Fixed-point Newton-Raphson n-th root: radicand^(1/degree), Q(32-F).F words.
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Direction  Handshake
// --------  -------------------------------  ---------  -------------------------
// command   start, radicand, degree, busy    in / out   taken when start & !busy
// config    cfg_valid, cfg_data, cfg_ready   in / out   taken when valid & ready
// result    done, root_value, saturated      out        one-cycle strobe on done
//
// Steps: one command runs S steps, S at most iteration_count; n = clamped
//   degree. Each step makes n truncating multiplies on one shared 32x32
//   multiplier (four partial products plus drain each) and a restoring
//   divide. A step whose quotient saturates up front skips the divide;
//   a vanishing derivative ends the command early.
// Reset: rst_n is asynchronous, active low; iteration_count returns to 100.
// Stalls: the receiver cannot hold off a result; busy stays high for the
//   whole command, and cfg_ready is low while busy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "newton_nth_root_assert.svh"

module newton_nth_root
    import nnr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int MAX_DEGREE = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // command
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [RAD_W-1:0] radicand,
    input  wire logic [DEG_W-1:0] degree,
    // configuration: iteration_count
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data,
    // result
    output logic                  done,
    output logic [RAD_W-1:0]      root_value,
    output logic                  saturated
);

    localparam logic [POW_W-1:0] ONE_FX   = POW_W'(1) << FRAC_BITS;
    localparam logic [EST_W-1:0] START_FX = EST_W'(START_VALUE) << FRAC_BITS;
    localparam int               MUL_W    = 2 * POW_W;

    // control
    nnr_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [2:0]       mul_cnt_reg, mul_cnt_next;
    logic [DEG_W-1:0] k_reg, k_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    logic             final_reg, final_next;   // current multiply gives x^n
    logic             sat_reg, sat_next;

    // datapath
    logic [RAD_W-1:0] c_reg, c_next;
    logic [DEG_W-1:0] n_reg, n_next;
    logic [EST_W-1:0] est_reg, est_next;
    logic [POW_W-1:0] pa_reg, pa_next;         // running power of x
    logic [MUL_W-1:0] acc_reg, acc_next;
    logic [POW_W-1:0] prod_reg, prod_next;
    logic [1:0]       psel_reg, psel_next;
    logic [POW_W-1:0] den_reg, den_next;
    logic [POW_W-1:0] rem_reg, rem_next;
    logic [POW_W-1:0] lo_reg, lo_next;
    logic [POW_W-1:0] q_reg, q_next;
    logic             neg_reg, neg_next;       // x^n < c: estimate grows
    logic [RAD_W-1:0] root_reg, root_next;
    logic             satout_reg, satout_next;

    // shared multiplier and helpers
    logic [31:0]          mul_a, mul_b;
    logic [POW_W-1:0]     mul_p;
    logic [POW_W-1:0]     est_ext;
    logic [MUL_W-1:0]     pp_shifted;
    logic                 mul_ovf;
    logic [POW_W-1:0]     mul_res;
    logic [POW_W+DEG_W-1:0] den_prod;
    logic                 den_ovf;
    logic                 pn_lt_c;
    logic [POW_W-1:0]     num;
    logic [POW_W-1:0]     num_hi;
    logic [POW_W-1:0]     rem_sh;
    logic                 q_ovf;
    logic [EST_W-1:0]     q_est;
    logic [EST_W:0]       est_sum;
    logic [DEG_W-1:0]     n_clamped;

    assign est_ext = {{(POW_W-EST_W){1'b0}}, est_reg};

    // operand halves picked by the partial-product index
    assign mul_a = mul_cnt_reg[1] ? pa_reg[63:32]  : pa_reg[31:0];
    assign mul_b = mul_cnt_reg[0] ? est_ext[63:32] : est_ext[31:0];
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    always_comb
    begin
        unique case (psel_reg)
            PP_LL:   pp_shifted = {64'b0, prod_reg};
            PP_LH,
            PP_HL:   pp_shifted = {32'b0, prod_reg, 32'b0};
            PP_HH:   pp_shifted = {prod_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
    end

    // truncating Q product, saturating at 2^63-1
    assign mul_ovf = |acc_reg[MUL_W-1:POW_W-1+FRAC_BITS];
    assign mul_res = mul_ovf ? POW_MAX : acc_reg[POW_W-1+FRAC_BITS:FRAC_BITS];

    // n * x^(n-1), narrow multiplier
    assign den_prod = {{DEG_W{1'b0}}, pa_reg} * {{POW_W{1'b0}}, n_reg};
    assign den_ovf  = |den_prod[POW_W+DEG_W-1:POW_W-1];

    assign pn_lt_c = pa_reg < {{(POW_W-RAD_W){1'b0}}, c_reg};
    assign num    = pn_lt_c ? ({{(POW_W-RAD_W){1'b0}}, c_reg} - pa_reg)
                            : (pa_reg - {{(POW_W-RAD_W){1'b0}}, c_reg});
    assign num_hi = num >> (POW_W - FRAC_BITS);
    assign rem_sh = {rem_reg[POW_W-2:0], lo_reg[POW_W-1]};

    assign q_ovf   = |q_reg[POW_W-1:EST_W];
    assign q_est   = q_ovf ? EST_MAX : q_reg[EST_W-1:0];
    assign est_sum = {1'b0, est_reg} + {1'b0, q_est};

    always_comb
    begin
        if (degree == '0)
            n_clamped = DEG_W'(1);
        else if ({1'b0, degree} > 5'(MAX_DEGREE))
            n_clamped = DEG_W'(MAX_DEGREE);
        else
            n_clamped = degree;
    end

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        iter_next    = iter_reg;
        step_next    = step_reg;
        mul_cnt_next = mul_cnt_reg;
        k_next       = k_reg;
        div_cnt_next = div_cnt_reg;
        final_next   = final_reg;
        sat_next     = sat_reg;
        c_next       = c_reg;
        n_next       = n_reg;
        est_next     = est_reg;
        pa_next      = pa_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        psel_next    = psel_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        root_next    = root_reg;
        satout_next  = satout_reg;

        if (cfg_valid && cfg_ready)
            iter_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    c_next     = radicand;
                    n_next     = n_clamped;
                    est_next   = START_FX;
                    sat_next   = 1'b0;
                    step_next  = '0;
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                if (step_reg == iter_reg || est_reg == '0)
                    state_next = ST_FIN;
                else
                begin
                    pa_next    = ONE_FX;
                    k_next     = DEG_W'(1);
                    final_next = 1'b0;
                    if (n_reg > DEG_W'(1))
                    begin
                        mul_cnt_next = '0;
                        acc_next     = '0;
                        state_next   = ST_MUL;
                    end
                    else
                        state_next = ST_DEN;
                end
            end

            // four partial products issue, each is added on the next clock
            ST_MUL:
            begin
                if (mul_cnt_reg != 3'd4)
                begin
                    prod_next = mul_p;
                    psel_next = mul_cnt_reg[1:0];
                end
                if (mul_cnt_reg != 3'd0)
                    acc_next = acc_reg + pp_shifted;
                if (mul_cnt_reg == 3'd4)
                    state_next = ST_MULEND;
                else
                    mul_cnt_next = mul_cnt_reg + 3'd1;
            end

            ST_MULEND:
            begin
                pa_next  = mul_res;
                sat_next = sat_reg | mul_ovf;
                if (final_reg)
                    state_next = ST_DIVSET;
                else if (k_reg + DEG_W'(1) == n_reg)
                    state_next = ST_DEN;
                else
                begin
                    k_next       = k_reg + DEG_W'(1);
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_MUL;
                end
            end

            ST_DEN:
            begin
                if (pa_reg == '0)
                begin
                    // derivative vanished: estimate collapses to zero
                    est_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    den_next     = den_ovf ? POW_MAX : den_prod[POW_W-1:0];
                    sat_next     = sat_reg | den_ovf;
                    final_next   = 1'b1;
                    mul_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_MUL;
                end
            end

            ST_DIVSET:
            begin
                neg_next = pn_lt_c;
                if (num_hi >= den_reg)
                begin
                    sat_next   = 1'b1;
                    q_next     = {{(POW_W-EST_W){1'b0}}, EST_MAX};
                    state_next = ST_UPDATE;
                end
                else
                begin
                    rem_next     = num_hi;
                    lo_next      = num << FRAC_BITS;
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end

            // restoring divide, one quotient bit per clock
            ST_DIV:
            begin
                lo_next = {lo_reg[POW_W-2:0], 1'b0};
                if (rem_sh >= den_reg)
                begin
                    rem_next = rem_sh - den_reg;
                    q_next   = {q_reg[POW_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[POW_W-2:0], 1'b0};
                end
                if (div_cnt_reg == 6'd63)
                    state_next = ST_UPDATE;
                else
                    div_cnt_next = div_cnt_reg + 6'd1;
            end

            ST_UPDATE:
            begin
                sat_next = sat_reg | q_ovf;
                if (neg_reg)
                begin
                    if (est_sum[EST_W])
                    begin
                        sat_next = 1'b1;
                        est_next = EST_MAX;
                    end
                    else
                        est_next = est_sum[EST_W-1:0];
                end
                else
                begin
                    if (q_est > est_reg)
                    begin
                        sat_next = 1'b1;
                        est_next = '0;
                    end
                    else
                        est_next = est_reg - q_est;
                end
                step_next  = step_reg + CNT_W'(1);
                state_next = ST_STEP;
            end

            ST_FIN:
            begin
                if (est_reg > {{(EST_W-RAD_W){1'b0}}, OUT_MAX})
                begin
                    root_next   = OUT_MAX;
                    satout_next = 1'b1;
                end
                else
                begin
                    root_next   = est_reg[RAD_W-1:0];
                    satout_next = sat_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            iter_reg    <= ITER_RESET;
            step_reg    <= '0;
            mul_cnt_reg <= '0;
            k_reg       <= '0;
            div_cnt_reg <= '0;
            final_reg   <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            iter_reg    <= iter_next;
            step_reg    <= step_next;
            mul_cnt_reg <= mul_cnt_next;
            k_reg       <= k_next;
            div_cnt_reg <= div_cnt_next;
            final_reg   <= final_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        n_reg      <= n_next;
        est_reg    <= est_next;
        pa_reg     <= pa_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        psel_reg   <= psel_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        root_reg   <= root_next;
        satout_reg <= satout_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign done       = done_reg;
    assign root_value = root_reg;
    assign saturated  = satout_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `NNR_ASSERT_NEXT(a_cmd_busy, clk, rst_n, start && !busy, busy,
        "command taken but block not busy")
    `NNR_ASSERT_NEXT(a_fin_done, clk, rst_n, state_reg == ST_FIN, done && !busy,
        "finish did not strobe a result")
    `NNR_ASSERT_NOW(a_div_rem, clk, rst_n, state_reg == ST_DIV, rem_reg < den_reg,
        "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> sim/tb_newton_nth_root.sv
// ----------------------------------------------------------------------------
// tb_newton_nth_root
// Self-checking bench for the fixed-point Newton n-th root block. Commands are
// driven from a backlog queue; each accepted word is run through a bit-exact
// root predictor, and every done strobe is checked against the oldest
// prediction. iteration_count is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_newton_nth_root;
    import nnr_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 8;

    typedef struct {
        logic [RAD_W-1:0] radicand;
        logic [DEG_W-1:0] degree;
    } root_cmd_t;

    typedef struct {
        logic [RAD_W-1:0] root_value;
        logic             saturated;
    } root_word_t;

    // DUT-facing signals; the driven inputs are known from time zero
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             start      = 1'b0;
    logic [RAD_W-1:0] radicand   = '0;
    logic [DEG_W-1:0] degree     = '0;
    logic             cfg_valid  = 1'b0;
    logic [CNT_W-1:0] cfg_data   = '0;
    logic             busy;
    logic             cfg_ready;
    logic             done;
    logic [RAD_W-1:0] root_value;
    logic             saturated;

    // bench state
    root_cmd_t        cmds_pending[$];    // commands not yet offered
    root_word_t       roots_due[$];       // predicted roots, oldest first
    logic [CNT_W-1:0] iter_setting = ITER_RESET;
    int               sender_idle_pct = 11;
    bit               drain_hold = 1'b0;  // sender waits for all roots back
    int               err_count = 0;
    int               cmds_taken = 0;
    int               roots_checked = 0;
    int               sat_seen = 0;
    int               zero_seen = 0;
    int               settings_written = 0;

    newton_nth_root #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .radicand   (radicand),
        .degree     (degree),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .root_value (root_value),
        .saturated  (saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Root predictor
    // ------------------------------------------------------------------------

    // a*b >> F, exact at 128 bits, truncating; saturates at POW_MAX
    function automatic logic [POW_W-1:0] mul_trunc(input logic [POW_W-1:0] a,
                                                   input logic [POW_W-1:0] b,
                                                   inout bit sat);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> FRAC_BITS;
        if (prod > {64'd0, POW_MAX})
        begin
            sat = 1'b1;
            return POW_MAX;
        end
        return prod[POW_W-1:0];
    endfunction

    // (num << F) / den, den nonzero; saturates at EST_MAX
    function automatic logic [POW_W-1:0] div_frac(input logic [POW_W-1:0] num,
                                                  input logic [POW_W-1:0] den,
                                                  inout bit sat);
        logic [127:0] quo;
        if ((num >> (POW_W - FRAC_BITS)) >= den)
        begin
            sat = 1'b1;
            return {16'd0, EST_MAX};
        end
        quo = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
        if (quo > {80'd0, EST_MAX})
        begin
            sat = 1'b1;
            return {16'd0, EST_MAX};
        end
        return quo[POW_W-1:0];
    endfunction

    function automatic int unsigned clamp_degree(input logic [DEG_W-1:0] deg);
        if (deg == 0)
            return 1;
        if (deg > MAX_DEGREE)
            return MAX_DEGREE;
        return deg;
    endfunction

    function automatic root_word_t predict_root(input logic [RAD_W-1:0] c,
                                                input logic [DEG_W-1:0] deg,
                                                input logic [CNT_W-1:0] steps);
        root_word_t  res;
        bit          sat;
        logic [63:0] n, x, acc, pn1, pn, den, q, cw;
        int unsigned k, s;
        sat = 1'b0;
        n   = clamp_degree(deg);
        cw  = {32'd0, c};
        x   = 64'(START_VALUE) << FRAC_BITS;
        for (s = 0; s < steps; s++)
        begin
            if (x == 0)
                break;
            acc = 64'd1 << FRAC_BITS;
            for (k = 1; k < n; k++)
                acc = mul_trunc(acc, x, sat);
            pn1 = acc;
            if (pn1 > POW_MAX / n)
            begin
                sat = 1'b1;
                den = POW_MAX;
            end
            else
                den = pn1 * n;
            // estimate collapsed: skip the divide, root is zero
            if (den == 0)
            begin
                x = 0;
                break;
            end
            pn = mul_trunc(pn1, x, sat);
            if (pn >= cw)
            begin
                q = div_frac(pn - cw, den, sat);
                // would go negative: clamp at zero
                if (q > x)
                begin
                    sat = 1'b1;
                    x   = 0;
                end
                else
                    x = x - q;
            end
            else
            begin
                q = div_frac(cw - pn, den, sat);
                if (q > {16'd0, EST_MAX} - x)
                begin
                    sat = 1'b1;
                    x   = {16'd0, EST_MAX};
                end
                else
                    x = x + q;
            end
        end
        // output word is only 32 bits wide
        if (x > {32'd0, OUT_MAX})
        begin
            sat = 1'b1;
            res.root_value = OUT_MAX;
        end
        else
            res.root_value = x[RAD_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: offers backlog words, holds start until busy drops,
    // idles at random and now and then waits for every root to come back.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        root_cmd_t nxt;
        if (!rst_n)
        begin
            start      <= 1'b0;
            radicand   <= '0;
            degree     <= '0;
            drain_hold = 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                // word taken at this edge
                roots_due.push_back(predict_root(radicand, degree, iter_setting));
                cmds_taken++;
            end
            if (drain_hold && roots_due.size() == 0)
                drain_hold = 1'b0;
            if (!drain_hold && cmds_pending.size() != 0
                && $urandom_range(99) >= sender_idle_pct)
            begin
                if (roots_due.size() != 0 && $urandom_range(99) < 3)
                begin
                    drain_hold = 1'b1;
                    start    <= 1'b0;
                    radicand <= $urandom;
                    degree   <= DEG_W'($urandom_range(15));
                end
                else
                begin
                    nxt = cmds_pending.pop_front();
                    start    <= 1'b1;
                    radicand <= nxt.radicand;
                    degree   <= nxt.degree;
                end
            end
            else
            begin
                // idle: junk on the payload
                start    <= 1'b0;
                radicand <= $urandom;
                degree   <= DEG_W'($urandom_range(15));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every done strobe is one word, checked in order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        root_word_t want;
        if (rst_n && done)
        begin
            if (roots_due.size() == 0)
            begin
                $error("unexpected root word: root_value %h saturated %b",
                       root_value, saturated);
                err_count++;
            end
            else
            begin
                want = roots_due.pop_front();
                if (root_value !== want.root_value)
                begin
                    $error("root_value: expected %h, actual %h",
                           want.root_value, root_value);
                    err_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b",
                           want.saturated, saturated);
                    err_count++;
                end
                roots_checked++;
                if (saturated === 1'b1)
                    sat_seen++;
                if (root_value === '0)
                    zero_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // block is quiet once nothing is queued, offered or owed
    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmds_pending.size() != 0 || start || roots_due.size() != 0);
    endtask

    task automatic set_iterations(input logic [CNT_W-1:0] steps);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= steps;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        cfg_data     <= CNT_W'($urandom);
        iter_setting = steps;
        settings_written++;
    endtask

    task automatic push_cmd(input logic [RAD_W-1:0] c, input logic [DEG_W-1:0] d);
        root_cmd_t cmd;
        cmd.radicand = c;
        cmd.degree   = d;
        cmds_pending.push_back(cmd);
    endtask

    // mostly in-range degrees; radicands mix full-range, small, exact powers
    function automatic root_cmd_t draw_cmd();
        root_cmd_t   cmd;
        logic [63:0] pw;
        int unsigned r, k, i;
        r = $urandom_range(99);
        if (r < 8)
            cmd.degree = '0;
        else if (r < 16)
            cmd.degree = DEG_W'($urandom_range(15, 9));
        else
            cmd.degree = DEG_W'($urandom_range(8, 1));
        case ($urandom_range(9))
            0, 1, 2: cmd.radicand = $urandom;
            3, 4:    cmd.radicand = $urandom_range(32'h000F_FFFF);
            5, 6:
            begin
                k  = $urandom_range(15);
                pw = 1;
                for (i = 0; i < clamp_degree(cmd.degree); i++)
                    pw = pw * k;
                if (pw < 65536)
                    cmd.radicand = {pw[15:0], 14'd0, 2'($urandom_range(3))};
                else
                    cmd.radicand = $urandom;
            end
            7:
            begin
                case ($urandom_range(2))
                    0:       cmd.radicand = '0;
                    1:       cmd.radicand = 32'd1;
                    default: cmd.radicand = OUT_MAX;
                endcase
            end
            default: cmd.radicand = $urandom | 32'hF000_0000;
        endcase
        return cmd;
    endfunction

    initial
    begin
        int idle_pct[3];
        int mode, half;
        idle_pct = '{11, 70, 0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset iteration_count (100) ---
        push_cmd(32'h0000_0000, 4'd2);     // zero radicand
        push_cmd(32'hFFFF_FFFF, 4'd1);     // largest radicand, first degree
        push_cmd(32'h0002_0000, 4'd2);     // sqrt(2)
        push_cmd(32'h001B_0000, 4'd3);     // cube root of 27

        // zero steps: start value comes straight back
        set_iterations(8'd0);
        push_cmd(32'h0010_0000, 4'd4);
        push_cmd(32'h1234_5678, 4'd0);
        push_cmd(32'hFFFF_FFFF, 4'd15);

        // longest runs; tiny radicands drive the estimate toward zero
        set_iterations(8'd255);
        push_cmd(32'h0000_0000, 4'd8);
        push_cmd(32'h0000_0001, 4'd8);
        push_cmd(32'hFFFF_FFFF, 4'd15);    // degree clamps to the max

        // single step over every degree from 1 to 8 plus 0 and 12, odd radicands
        set_iterations(8'd1);
        push_cmd(32'h0000_0001, 4'd1);
        push_cmd(32'hFFFF_FFFF, 4'd2);
        push_cmd(32'h8000_0000, 4'd3);
        push_cmd(32'h0000_FFFF, 4'd4);
        push_cmd(32'hFFFF_FFFF, 4'd5);
        push_cmd(32'h0000_0000, 4'd6);
        push_cmd(32'h7FFF_FFFF, 4'd7);
        push_cmd(32'hFFFF_FFFF, 4'd8);
        push_cmd(32'h0001_0000, 4'd0);
        push_cmd(32'h0001_0000, 4'd12);

        // --- random: sender idle 11%, then 70%, then never ---
        for (mode = 0; mode < 3; mode++)
        begin
            for (half = 0; half < 2; half++)
            begin
                case ({mode[1:0], half[0]})
                    3'b000:  set_iterations(CNT_W'($urandom_range(8, 2)));
                    3'b001:  set_iterations(8'd24);
                    3'b010:  set_iterations(8'd1);
                    3'b011:  set_iterations(CNT_W'($urandom_range(24, 9)));
                    default: set_iterations(CNT_W'($urandom_range(24, 2)));
                endcase
                // idle rate changes only while the block is quiet
                sender_idle_pct = idle_pct[mode];
                repeat (14) cmds_pending.push_back(draw_cmd());
            end
        end

        wait_idle();
        // quiet tail: any stray strobe here is an error
        repeat (200) @(posedge clk);

        $display("root words: %0d accepted, %0d checked, %0d saturated, %0d zero",
                 cmds_taken, roots_checked, sat_seen, zero_seen);
        $display("iteration_count rewritten %0d times (0, 1, 255 and random counts)",
                 settings_written);
        if (err_count == 0 && roots_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, well past the slowest legal run
    initial
    begin
        #30000000;
        $display("timeout with %0d root words still due", roots_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
